// ===== design/lcg48_pkg.sv =====
// shared types, constants and codes of the 48-bit lcg random draw block
// no dependencies; imported by every module under design/

package lcg48_pkg;

  localparam int unsigned StateW = 48;
  localparam int unsigned ValueW = 32;
  localparam int unsigned CountW = 6;
  localparam int unsigned DigitW = 12;
  localparam int unsigned MulSteps = 3;
  localparam int unsigned DivSteps = 32;

  // generator constants
  localparam logic [StateW-1:0] LcgMult = 48'h0005_DEEC_E66D;
  localparam logic [StateW-1:0] LcgAdd = 48'h0000_0000_000B;
  // multiplier split into 12-bit digits, lowest first
  localparam logic [DigitW*MulSteps-1:0] LcgMultDigits = LcgMult[DigitW*MulSteps-1:0];

  // apb register map, one 64-bit register at byte address 0
  localparam int unsigned AddrW = 4;
  localparam int unsigned ApbDataW = 64;
  localparam logic RegSeed = 1'b0;

  // draw kinds
  typedef enum logic [1:0] {
    OP_TOP_BITS = 2'd0,
    OP_MOD_BOUND = 2'd1,
    OP_RANGE = 2'd2,
    OP_NOP = 2'd3
  } lcg48_op_e;

  // sequencer states
  typedef enum logic [1:0] {
    ST_IDLE = 2'd0,
    ST_MUL = 2'd1,
    ST_DIV = 2'd2,
    ST_DONE = 2'd3
  } lcg48_state_e;

  // divider status toward the sequencer
  typedef struct packed {
    logic busy;
    logic done;
  } lcg48_div_stat_t;

endpackage

// ===== design/lcg48_mac.sv =====
// one multiply-accumulate step of the lcg update: acc + state * digit << 12*step
// depends on lcg48_pkg

module lcg48_mac (
  input  logic [lcg48_pkg::StateW-1:0] acc_i,
  input  logic [lcg48_pkg::StateW-1:0] state_i,
  input  logic [1:0]                   step_i,
  output logic [lcg48_pkg::StateW-1:0] sum_o
);
  import lcg48_pkg::*;

  logic [DigitW-1:0]        digit;
  logic [StateW+DigitW-1:0] prod;
  logic [StateW-1:0]        part;
  logic [StateW-1:0]        inc;

  always_comb begin
    unique case (step_i)
      2'd0: begin
        digit = LcgMultDigits[DigitW-1:0];
      end
      2'd1: begin
        digit = LcgMultDigits[2*DigitW-1:DigitW];
      end
      default: begin
        digit = LcgMultDigits[3*DigitW-1:2*DigitW];
      end
    endcase
  end

  assign prod = {{DigitW{1'b0}}, state_i} * {{StateW{1'b0}}, digit};

  always_comb begin
    unique case (step_i)
      2'd0: begin
        part = prod[StateW-1:0];
      end
      2'd1: begin
        part = {prod[StateW-DigitW-1:0], {DigitW{1'b0}}};
      end
      default: begin
        part = {prod[StateW-2*DigitW-1:0], {(2*DigitW){1'b0}}};
      end
    endcase
  end

  // the increment rides along with the first partial product
  assign inc = (step_i == 2'd0) ? LcgAdd : '0;
  assign sum_o = acc_i + part + inc;

endmodule

// ===== design/lcg48_div.sv =====
// restoring radix-2 remainder unit, one quotient bit per cycle
// depends on lcg48_pkg

module lcg48_div (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         start_i,
  input  logic [lcg48_pkg::ValueW-1:0] dividend_i,
  input  logic [lcg48_pkg::ValueW-1:0] divisor_i,
  output lcg48_pkg::lcg48_div_stat_t   stat_o,
  output logic [lcg48_pkg::ValueW-1:0] rem_o
);
  import lcg48_pkg::*;

  localparam int unsigned CntW = $clog2(DivSteps);
  localparam logic [CntW-1:0] CntLast = CntW'(DivSteps - 1);

  logic [ValueW-1:0] rem_q, rem_d;
  logic [ValueW-1:0] num_q;
  logic [ValueW-1:0] dvs_q;
  logic [CntW-1:0]   cnt_q;
  logic              busy_q;
  logic              done_q;
  logic [ValueW:0]   trial;
  logic [ValueW:0]   diff;

  assign trial = {rem_q, num_q[ValueW-1]};
  assign diff = trial - {1'b0, dvs_q};
  assign rem_d = diff[ValueW] ? trial[ValueW-1:0] : diff[ValueW-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q <= '0;
    end else begin
      // done pulses for one cycle after the last step
      done_q <= busy_q && !start_i && (cnt_q == CntLast);
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + CntW'(1);
        if (cnt_q == CntLast) begin
          busy_q <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= '0;
      num_q <= dividend_i;
      dvs_q <= divisor_i;
    end else if (busy_q) begin
      rem_q <= rem_d;
      num_q <= {num_q[ValueW-2:0], 1'b0};
    end
  end

  assign stat_o.busy = busy_q;
  assign stat_o.done = done_q;
  assign rem_o = rem_q;

endmodule

// ===== design/lcg48_random_draw.sv =====
// top level of the 48-bit lcg random draw block: sequencer, seed register, result beat
// depends on lcg48_pkg, lcg48_mac and lcg48_div

// A draw beat on the slave stream carries its kind in tuser and its operands in
// tdata. Every draw (except the unused kind 3, which returns 0 and leaves the
// generator alone) first advances the 48-bit state as state*0x5DEECE66D+11 mod
// 2^48, done as three 48x12 multiply-accumulate steps through one shared unit.
// Kind 0 then returns the top bit_count bits (count 0 gives 0, above 32 means 32);
// kind 1 returns the top 32 state bits modulo bound; kind 2 returns range_min plus
// that value modulo range_max-range_min+1, all with 32-bit wrap. A zero modulus
// returns 0 with zero_modulus set. After an accepted beat, kind 0 (and a zero
// modulus) runs the three multiply steps and then loads its result, kind 3
// goes straight to the result, and kinds 1 and 2 add the bit-serial remainder
// unit after the multiply. The slave side is ready again in the cycle after the
// result is loaded, so a new draw is never taken before the last result is loaded.
// The slave side is ready only while the sequencer is idle; one finished result
// may wait in the output register while the next draw is already being worked on.
// Writing the seed register over apb (byte address 0, 64-bit data, low 48 bits
// used) loads the state with seed xor 0x5DEECE66D at once; reset does the same
// for seed 0. Write the seed only while no draw is in flight.

module lcg48_random_draw (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  // apb configuration port
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [lcg48_pkg::AddrW-1:0]    paddr,
  input  logic [lcg48_pkg::ApbDataW-1:0] pwdata,
  output logic [lcg48_pkg::ApbDataW-1:0] prdata,
  output logic                           pready,
  // draw requests
  input  logic                           s_axis_tvalid_i,
  output logic                           s_axis_tready_o,
  // [5:0] bit_count, [37:6] bound, [69:38] range_min, [101:70] range_max, [103:102] zero
  input  logic [103:0]                   s_axis_tdata_i,
  // [1:0] operation
  input  logic [1:0]                     s_axis_tuser_i,
  // results
  output logic                           m_axis_tvalid_o,
  input  logic                           m_axis_tready_i,
  // [31:0] value
  output logic [31:0]                    m_axis_tdata_o,
  // [0] zero_modulus
  output logic [0:0]                     m_axis_tuser_o
);
  import lcg48_pkg::*;

  localparam logic [1:0] MulLast = 2'(MulSteps - 1);

  // input beat unpacking
  logic [CountW-1:0] in_bits;
  logic [ValueW-1:0] in_bound;
  logic [ValueW-1:0] in_min;
  logic [ValueW-1:0] in_max;
  lcg48_op_e         in_op;

  assign in_bits = s_axis_tdata_i[5:0];
  assign in_bound = s_axis_tdata_i[37:6];
  assign in_min = s_axis_tdata_i[69:38];
  assign in_max = s_axis_tdata_i[101:70];
  assign in_op = lcg48_op_e'(s_axis_tuser_i);

  lcg48_state_e      fsm_q, fsm_d;
  lcg48_op_e         op_q;
  logic [CountW-1:0] bits_q;
  logic [ValueW-1:0] mod_q;
  logic [ValueW-1:0] min_q;
  logic [StateW-1:0] seed_q;
  logic [StateW-1:0] lcg_q;
  logic [StateW-1:0] acc_q;
  logic [1:0]        mcnt_q;
  logic              out_valid_q;
  logic [ValueW-1:0] out_data_q;
  logic              out_flag_q;

  // control from the output decoder
  logic in_acc;
  logic mul_step;
  logic mul_last;
  logic div_start;
  logic res_load;
  logic cfg_wr;

  logic [StateW-1:0] mac_sum;
  lcg48_div_stat_t   div_stat;
  logic [ValueW-1:0] div_rem;

  // result selection
  logic [CountW-1:0] bits_sat;
  logic [CountW-1:0] shamt;
  logic [StateW-1:0] top_shift;
  logic [ValueW-1:0] res_data;
  logic              res_flag;
  logic              out_free;

  // apb: always ready, one register
  assign pready = 1'b1;
  assign cfg_wr = psel & penable & pwrite & (paddr[3] == RegSeed);
  assign prdata = {{(ApbDataW-StateW){1'b0}}, seed_q};

  lcg48_mac u_mac (
    .acc_i   (acc_q),
    .state_i (lcg_q),
    .step_i  (mcnt_q),
    .sum_o   (mac_sum)
  );

  lcg48_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (mac_sum[StateW-1:StateW-ValueW]),
    .divisor_i  (mod_q),
    .stat_o     (div_stat),
    .rem_o      (div_rem)
  );

  assign out_free = !out_valid_q || m_axis_tready_i;

  // next state
  always_comb begin
    fsm_d = fsm_q;
    unique case (fsm_q)
      ST_IDLE: begin
        if (s_axis_tvalid_i) begin
          fsm_d = (in_op == OP_NOP) ? ST_DONE : ST_MUL;
        end
      end
      ST_MUL: begin
        if (mcnt_q == MulLast) begin
          if (op_q == OP_TOP_BITS || mod_q == '0) begin
            fsm_d = ST_DONE;
          end else begin
            fsm_d = ST_DIV;
          end
        end
      end
      ST_DIV: begin
        if (div_stat.done) begin
          fsm_d = ST_DONE;
        end
      end
      default: begin
        if (out_free) begin
          fsm_d = ST_IDLE;
        end
      end
    endcase
  end

  // sequencer outputs
  always_comb begin
    s_axis_tready_o = 1'b0;
    mul_step = 1'b0;
    mul_last = 1'b0;
    div_start = 1'b0;
    res_load = 1'b0;
    unique case (fsm_q)
      ST_IDLE: begin
        s_axis_tready_o = 1'b1;
      end
      ST_MUL: begin
        mul_step = 1'b1;
        mul_last = (mcnt_q == MulLast);
        div_start = mul_last && op_q != OP_TOP_BITS && mod_q != '0;
      end
      ST_DIV: begin
      end
      default: begin
        res_load = out_free;
      end
    endcase
  end

  assign in_acc = s_axis_tvalid_i & s_axis_tready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fsm_q <= ST_IDLE;
      seed_q <= '0;
      lcg_q <= LcgMult;
      out_valid_q <= 1'b0;
      mcnt_q <= '0;
    end else begin
      fsm_q <= fsm_d;
      if (cfg_wr) begin
        seed_q <= pwdata[StateW-1:0];
        lcg_q <= pwdata[StateW-1:0] ^ LcgMult;
      end else if (mul_last) begin
        lcg_q <= mac_sum;
      end
      if (in_acc) begin
        mcnt_q <= '0;
      end else if (mul_step) begin
        mcnt_q <= mcnt_q + 2'd1;
      end
      if (res_load) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // operand capture and accumulator, no reset needed
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      op_q <= in_op;
      bits_q <= in_bits;
      min_q <= in_min;
      mod_q <= (in_op == OP_MOD_BOUND) ? in_bound : (in_max - in_min + 32'd1);
      acc_q <= '0;
    end else if (mul_step) begin
      acc_q <= mac_sum;
    end
    if (res_load) begin
      out_data_q <= res_data;
      out_flag_q <= res_flag;
    end
  end

  // top bits: count saturates at 32, count zero gives zero
  assign bits_sat = (bits_q > CountW'(ValueW)) ? CountW'(ValueW) : bits_q;
  assign shamt = CountW'(StateW) - bits_sat;
  assign top_shift = lcg_q >> shamt;

  always_comb begin
    res_data = '0;
    res_flag = 1'b0;
    unique case (op_q)
      OP_TOP_BITS: begin
        res_data = (bits_q == '0) ? '0 : top_shift[ValueW-1:0];
      end
      OP_MOD_BOUND: begin
        res_flag = (mod_q == '0);
        res_data = res_flag ? '0 : div_rem;
      end
      OP_RANGE: begin
        res_flag = (mod_q == '0);
        res_data = res_flag ? '0 : (min_q + div_rem);
      end
      default: begin
      end
    endcase
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o = out_data_q;
  assign m_axis_tuser_o = out_flag_q;

`ifndef SYNTHESIS
  // a taken draw blocks the slave side until its result is built
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |=> !s_axis_tready_o)
    else $error("draw accepted while previous draw in flight");

  // a flagged result always carries a zero value
  a_flag_zero_value: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && m_axis_tuser_o[0]) |-> (m_axis_tdata_o == '0))
    else $error("zero modulus result with nonzero value");

  // the remainder unit ends below its divisor
  a_rem_below_mod: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_stat.done |-> (div_rem < mod_q))
    else $error("remainder not below modulus");

  // the divider only runs while the sequencer waits on it
  a_div_in_div_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_stat.busy |-> (fsm_q == ST_DIV))
    else $error("divider busy outside of division state");
`endif

endmodule
